// ===== hw/rtl/ddo_pkg.sv =====
// shared types, codes and the quarter-wave sine table for the odometry block
package ddo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_LEN     = 1 << (SINE_TABLE_BITS - 2);
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // multiplier operand select codes
    localparam logic [2:0] MS_PX  = 3'd0;
    localparam logic [2:0] MS_PY  = 3'd1;
    localparam logic [2:0] MS_XLO = 3'd2;
    localparam logic [2:0] MS_XHI = 3'd3;
    localparam logic [2:0] MS_YLO = 3'd4;
    localparam logic [2:0] MS_YHI = 3'd5;
    localparam logic [2:0] MS_TLO = 3'd6;
    localparam logic [2:0] MS_THI = 3'd7;

    // accumulator commit target codes
    localparam logic [1:0] CS_X = 2'd0;
    localparam logic [1:0] CS_Y = 2'd1;
    localparam logic [1:0] CS_T = 2'd2;

    // register indexes
    localparam logic REG_HALF_RADIUS = 1'b0;
    localparam logic REG_TURN_SCALE  = 1'b1;

    typedef logic [QUARTER_LEN:0][14:0] t_sine_tab;

    typedef struct packed {
        logic       load_in;
        logic       sum_en;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       commit_en;
        logic [1:0] commit_sel;
        logic       out_load;
    } t_ddo_cmd;

    typedef struct packed {
        logic out_valid;
    } t_ddo_status;

    // integer series for sin on [0, pi/2], Q1.15 result clamped to 32767
    function automatic t_sine_tab build_sine();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x  = (longint'(k) * PI_HALF_Q30) / QUARTER_LEN;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            s  = (s + (64'd1 << 14)) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            tab[k] = s[14:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    // full-wave lookup from the quarter table, signed Q1.15
    function automatic logic signed [15:0] sine_at(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0]                 quad;
        logic [SINE_TABLE_BITS-3:0] r;
        logic [SINE_TABLE_BITS-2:0] j;
        logic [15:0]                v;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        r    = idx[SINE_TABLE_BITS-3:0];
        j    = quad[0] ? ((SINE_TABLE_BITS-1)'(QUARTER_LEN) - {1'b0, r}) : {1'b0, r};
        v    = {1'b0, SINE_TAB[j]};
        return quad[1] ? $signed(-v) : $signed(v);
    endfunction

endpackage

// ===== hw/rtl/ddo_ctrl.sv =====
// sequencer for the odometry datapath: one item at a time over a shared multiplier
module ddo_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic                 i_m_tready,
    input  ddo_pkg::t_ddo_status i_status,
    output ddo_pkg::t_ddo_cmd    o_cmd
);
    import ddo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_PY   = 4'd2;
    localparam logic [3:0] S_XLO  = 4'd3;
    localparam logic [3:0] S_XHI  = 4'd4;
    localparam logic [3:0] S_YLO  = 4'd5;
    localparam logic [3:0] S_YHI  = 4'd6;
    localparam logic [3:0] S_TLO  = 4'd7;
    localparam logic [3:0] S_THI  = 4'd8;
    localparam logic [3:0] S_TCOM = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       slot_free;

    assign slot_free  = !i_status.out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_s_tvalid;
                if (i_s_tvalid) n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.sum_en  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_PX;
                n_state       = S_PY;
            end
            S_PY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_PY;
                n_state       = S_XLO;
            end
            S_XLO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_XLO;
                n_state       = S_XHI;
            end
            S_XHI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_XHI;
                n_state       = S_YLO;
            end
            S_YLO: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_sel    = MS_YLO;
                o_cmd.commit_en  = 1'b1;
                o_cmd.commit_sel = CS_X;
                n_state          = S_YHI;
            end
            S_YHI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_YHI;
                n_state       = S_TLO;
            end
            S_TLO: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_sel    = MS_TLO;
                o_cmd.commit_en  = 1'b1;
                o_cmd.commit_sel = CS_Y;
                n_state          = S_THI;
            end
            S_THI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_THI;
                n_state       = S_TCOM;
            end
            S_TCOM: begin
                o_cmd.commit_en  = 1'b1;
                o_cmd.commit_sel = CS_T;
                n_state          = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_load = slot_free;
                if (slot_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> (r_state == S_DIFF))
        else $error("accepted item did not start the sequence");

    a_diff_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF) |-> $past(r_state == S_IDLE && i_s_tvalid))
        else $error("sequence started without an accepted item");

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!i_status.out_valid || i_m_tready))
        else $error("result register overwritten while still held");

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("no return to idle after result load");

endmodule

// ===== hw/rtl/ddo_dp.sv =====
// odometry datapath: deltas, trig lookup, shared multiplier, saturating accumulators
module ddo_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ddo_pkg::t_ddo_cmd    i_cmd,
    output ddo_pkg::t_ddo_status o_status,
    input  logic [31:0]          i_left_angle,
    input  logic [31:0]          i_right_angle_raw,
    input  logic [15:0]          i_heading,
    input  logic [15:0]          i_half_radius,
    input  logic [15:0]          i_turn_scale,
    input  logic                 i_m_tready,
    output logic [31:0]          o_pos_x,
    output logic [31:0]          o_pos_y,
    output logic [31:0]          o_theta
);
    import ddo_pkg::*;

    localparam logic signed [40:0] ACC_MAX = 41'sd2147483647;
    localparam logic signed [40:0] ACC_MIN = -41'sd2147483648;

    logic [31:0]          r_prev_left;
    logic [31:0]          r_prev_right;
    logic [31:0]          r_acc_x;
    logic [31:0]          r_acc_y;
    logic [31:0]          r_acc_t;
    logic [32:0]          r_dl;
    logic [32:0]          r_dr;
    logic [33:0]          r_sum;
    logic [33:0]          r_diff;
    logic signed [15:0]   r_sn;
    logic signed [15:0]   r_cs;
    logic [20:0]          r_px;
    logic [20:0]          r_py;
    logic [55:0]          r_prod;
    logic [31:0]          r_out_x;
    logic [31:0]          r_out_y;
    logic [31:0]          r_out_t;
    logic                 r_out_valid;

    logic [31:0]                right_neg;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic signed [21:0]         mul_a;
    logic signed [17:0]         mul_b;
    logic signed [39:0]         mul_p;
    logic signed [39:0]         mul_rnd12;
    logic [55:0]                mul_ext;
    logic [39:0]                step;
    logic [31:0]                acc_cur;
    logic signed [40:0]         acc_sum;
    logic [31:0]                acc_sat;

    // negate right wheel, most negative value clamps to max
    assign right_neg = (i_right_angle_raw == 32'h8000_0000) ? 32'h7FFF_FFFF
                                                            : (32'd0 - i_right_angle_raw);
    assign idx       = i_heading[15 -: SINE_TABLE_BITS];

    always_comb begin
        case (i_cmd.mul_sel)
            MS_PX: begin
                mul_a = $signed({6'd0, i_half_radius});
                mul_b = $signed({{2{r_sn[15]}}, r_sn});
            end
            MS_PY: begin
                mul_a = $signed({6'd0, i_half_radius});
                mul_b = $signed({{2{r_cs[15]}}, r_cs});
            end
            MS_XLO: begin
                mul_a = $signed({r_px[20], r_px});
                mul_b = $signed({1'b0, r_sum[16:0]});
            end
            MS_XHI: begin
                mul_a = $signed({r_px[20], r_px});
                mul_b = $signed({r_sum[33], r_sum[33:17]});
            end
            MS_YLO: begin
                mul_a = $signed({r_py[20], r_py});
                mul_b = $signed({1'b0, r_sum[16:0]});
            end
            MS_YHI: begin
                mul_a = $signed({r_py[20], r_py});
                mul_b = $signed({r_sum[33], r_sum[33:17]});
            end
            MS_TLO: begin
                mul_a = $signed({6'd0, i_turn_scale});
                mul_b = $signed({1'b0, r_diff[16:0]});
            end
            MS_THI: begin
                mul_a = $signed({6'd0, i_turn_scale});
                mul_b = $signed({r_diff[33], r_diff[33:17]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign mul_rnd12 = mul_p + 40'sd2048;
    assign mul_ext   = {{16{mul_p[39]}}, mul_p};

    // round already folded into the low partial product
    always_comb begin
        case (i_cmd.commit_sel)
            CS_X: begin
                step    = {{3{r_prod[55]}}, r_prod[55:19]};
                acc_cur = r_acc_x;
            end
            CS_Y: begin
                step    = {{3{r_prod[55]}}, r_prod[55:19]};
                acc_cur = r_acc_y;
            end
            CS_T: begin
                step    = r_prod[55:16];
                acc_cur = r_acc_t;
            end
            default: begin
                step    = '0;
                acc_cur = '0;
            end
        endcase
    end

    assign acc_sum = $signed({{9{acc_cur[31]}}, acc_cur}) + $signed({step[39], step});

    always_comb begin
        if (acc_sum > ACC_MAX) begin
            acc_sat = 32'h7FFF_FFFF;
        end else if (acc_sum < ACC_MIN) begin
            acc_sat = 32'h8000_0000;
        end else begin
            acc_sat = acc_sum[31:0];
        end
    end

    // model state and handshake flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_acc_t      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_prev_left  <= i_left_angle;
                r_prev_right <= right_neg;
            end
            if (i_cmd.commit_en) begin
                case (i_cmd.commit_sel)
                    CS_X:    r_acc_x <= acc_sat;
                    CS_Y:    r_acc_y <= acc_sat;
                    CS_T:    r_acc_t <= acc_sat;
                    default: r_acc_t <= r_acc_t;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_dl <= {i_left_angle[31], i_left_angle} - {r_prev_left[31], r_prev_left};
            r_dr <= {right_neg[31], right_neg} - {r_prev_right[31], r_prev_right};
            r_sn <= sine_at(idx);
            r_cs <= sine_at(idx + SINE_TABLE_BITS'(QUARTER_LEN));
        end
        if (i_cmd.sum_en) begin
            r_sum  <= {r_dl[32], r_dl} + {r_dr[32], r_dr};
            r_diff <= {r_dr[32], r_dr} - {r_dl[32], r_dl};
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MS_PX:  r_px   <= mul_rnd12[32:12];
                MS_PY:  r_py   <= mul_rnd12[32:12];
                MS_XLO: r_prod <= mul_ext + 56'd262144;
                MS_YLO: r_prod <= mul_ext + 56'd262144;
                MS_TLO: r_prod <= mul_ext + 56'd32768;
                MS_XHI: r_prod <= r_prod + (mul_ext << 17);
                MS_YHI: r_prod <= r_prod + (mul_ext << 17);
                MS_THI: r_prod <= r_prod + (mul_ext << 17);
                default: r_prod <= r_prod;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_x <= r_acc_x;
            r_out_y <= r_acc_y;
            r_out_t <= r_acc_t;
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_pos_x            = r_out_x;
    assign o_pos_y            = r_out_y;
    assign o_theta            = r_out_t;

endmodule

// ===== hw/rtl/diff_drive_odometry.sv =====
// top level of the differential drive odometry block with its register port
//
// input stream (s_axis): one transfer per sample carries the absolute left
// wheel angle, the raw right wheel angle and the robot heading. output
// stream (m_axis): one transfer per sample carries the x, y and theta
// accumulators after the update.
// one item is taken at a time, and only in the idle state: an accept step,
// then the work on one shared 22x18 multiplier (eight partial products and
// three saturating commits), then a step that moves the accumulators into
// the output register. m_axis_tvalid rises at the same clock edge at which
// s_axis_tready comes back.
// the output register decouples the sides: the next input is taken while a
// result still waits; if the receiver stalls longer than an item takes, the
// sequencer holds in its last step until the output register is free.
// reset clears the previous wheel angles and all accumulators to zero and
// loads half_radius = 1311 and turn_scale = 6554.
// registers (apb, byte address): 0x0 half_radius, 0x4 turn_scale, both
// unsigned q0.16 in the low 16 bits; write only while the block is idle.
module diff_drive_odometry (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // left_angle, right_angle_raw, heading
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // pos_x, pos_y, theta
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ddo_pkg::*;

    logic [15:0] r_half_radius;
    logic [15:0] r_turn_scale;
    logic        cfg_wr;
    logic        cfg_idx;

    t_ddo_cmd    cmd;
    t_ddo_status status;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] theta;

    // register port, zero wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_radius <= 16'd1311;
            r_turn_scale  <= 16'd6554;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HALF_RADIUS: r_half_radius <= pwdata[15:0];
                REG_TURN_SCALE:  r_turn_scale  <= pwdata[15:0];
                default:         r_turn_scale  <= r_turn_scale;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HALF_RADIUS: prdata = {16'd0, r_half_radius};
            REG_TURN_SCALE:  prdata = {16'd0, r_turn_scale};
            default:         prdata = '0;
        endcase
    end

    // sequencer
    ddo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic and state
    ddo_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_left_angle      (s_axis_tdata[31:0]),
        .i_right_angle_raw (s_axis_tdata[63:32]),
        .i_heading         (s_axis_tdata[79:64]),
        .i_half_radius     (r_half_radius),
        .i_turn_scale      (r_turn_scale),
        .i_m_tready        (m_axis_tready),
        .o_pos_x           (pos_x),
        .o_pos_y           (pos_y),
        .o_theta           (theta)
    );

    assign m_axis_tvalid = status.out_valid;
    assign m_axis_tdata  = {theta, pos_y, pos_x};

endmodule
